// ----- design/swec_pkg.sv -----
// Shared constants and types for the sliding-window event counter.
`timescale 1ns / 1ps

package swec_pkg;

	localparam int STORE_DEPTH_DEF = 64;

	localparam int TIME_W = 32;
	localparam int WIN_W  = 20;
	localparam int EVT_W  = 7;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3000);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_CHECK = 2'b10
	} swec_state_t;

endpackage

// ----- design/swec_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module swec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- design/swec_ctrl.sv -----
// Head/count sequencer: expiry from the head, append at the tail, result register.
`timescale 1ns / 1ps

module swec_ctrl
	import swec_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [WIN_W-1:0]               window_length,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [TIME_W-1:0]              event_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [EVT_W-1:0]               events_in_window,
	output logic                           overflowed,
	output logic                           ram_wr_en,
	output logic [$clog2(STORE_DEPTH)-1:0] ram_wr_addr,
	output logic [TIME_W-1:0]              ram_wr_data,
	output logic                           ram_rd_en,
	output logic [$clog2(STORE_DEPTH)-1:0] ram_rd_addr,
	input  logic [TIME_W-1:0]              ram_rd_data
);

	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

	localparam logic [ADDR_W:0]  DEPTH_A = (ADDR_W+1)'(STORE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

	swec_state_t        state_q;
	logic [ADDR_W-1:0]  head_q;
	logic [CNT_W-1:0]   count_q;
	logic [TIME_W-1:0]  time_s1;
	logic [TIME_W-1:0]  lower_s1;
	logic               out_valid_q;
	logic [EVT_W-1:0]   events_q;
	logic               ovf_q;

	logic               accept;
	logic               in_check;
	logic               expire;
	logic               full;
	logic               out_free;
	logic               finalize;
	logic [ADDR_W:0]    head_p1;
	logic [ADDR_W-1:0]  head_inc;
	logic [ADDR_W:0]    tail_sum;
	logic [ADDR_W-1:0]  tail;
	logic [TIME_W-1:0]  lower;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_check = (state_q == ST_CHECK);
	assign in_stall = (state_q != ST_IDLE);

	// inclusive lower bound, saturating at zero
	assign lower = (event_time >= TIME_W'(window_length))
		? event_time - TIME_W'(window_length) : '0;

	assign head_p1  = {1'b0, head_q} + (ADDR_W+1)'(1);
	assign head_inc = (head_p1 == DEPTH_A) ? '0 : head_p1[ADDR_W-1:0];

	// when full, head + depth wraps back onto head: the oldest word is overwritten
	assign tail_sum = {1'b0, head_q} + (ADDR_W+1)'(count_q);
	always_comb begin
		if (tail_sum >= DEPTH_A) begin
			tail = ADDR_W'(tail_sum - DEPTH_A);
		end else begin
			tail = tail_sum[ADDR_W-1:0];
		end
	end

	assign expire   = in_check && (count_q != '0) && (ram_rd_data < lower_s1);
	assign full     = (count_q == DEPTH_C);
	assign out_free = !out_valid_q || !out_stall;
	assign finalize = in_check && !expire && out_free;

	// head is read on accept and again after every pop
	assign ram_rd_en   = accept || expire;
	assign ram_rd_addr = accept ? head_q : head_inc;
	assign ram_wr_en   = finalize;
	assign ram_wr_addr = tail;
	assign ram_wr_data = time_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			time_s1  <= event_time;
			lower_s1 <= lower;
		end
		if (finalize) begin
			events_q <= full ? EVT_W'(count_q) : EVT_W'(count_q + CNT_W'(1));
			ovf_q    <= full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (finalize) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (expire || (finalize && full)) begin
				head_q <= head_inc;
			end

			if (expire) begin
				count_q <= count_q - CNT_W'(1);
			end else if (finalize && !full) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (finalize) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign events_in_window = events_q;
	assign overflowed       = ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above store depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < DEPTH_A[ADDR_W-1:0] || DEPTH_A == (ADDR_W+1)'(1 << ADDR_W))
		else $error("head index out of range");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		expire |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not decrement count");

	a_append_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		finalize |=> count_q != '0 && out_valid_q)
		else $error("append left store empty or no result");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr_en && ram_rd_en))
		else $error("read and write issued together");

endmodule

// ----- design/sliding_window_event_counter_core.sv -----
// Top level of the sliding-window event counter: window register, store, sequencer.
//
//  channel        | direction | handshake                  | payload
//  ---------------+-----------+----------------------------+---------------------------------
//  event in       | in        | in_valid / in_stall        | event_time[31:0]
//  count out      | out       | out_valid / out_stall      | events_in_window[6:0], overflowed
//  window config  | in        | window_length_we           | window_length[19:0]
//
// Each word is checked against the stored timestamps from the head: the single read port of the
// timestamp store fetches one head entry per cycle while entries expire. Expiry is
// amortised; a new word is not taken until the previous one has been appended.
// A pending result waits in the output register; the next word is still taken meanwhile.
// Reset clears head, count and control; the store needs no clearing pass since only
// entries that have been written are ever compared.
`timescale 1ns / 1ps

module sliding_window_event_counter_core
	import swec_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                window_length_we,
	input  logic [WIN_W-1:0]    window_length,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [TIME_W-1:0]   event_time,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [EVT_W-1:0]    events_in_window,
	output logic                overflowed
);

	localparam int ADDR_W = $clog2(STORE_DEPTH);

	logic [WIN_W-1:0]   window_q;
	logic               ram_wr_en;
	logic [ADDR_W-1:0]  ram_wr_addr;
	logic [TIME_W-1:0]  ram_wr_data;
	logic               ram_rd_en;
	logic [ADDR_W-1:0]  ram_rd_addr;
	logic [TIME_W-1:0]  ram_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (window_length_we) begin
			window_q <= window_length;
		end
	end

	swec_ram #(
		.WIDTH(TIME_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	swec_ctrl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.window_length    (window_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.event_time       (event_time),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.events_in_window (events_in_window),
		.overflowed       (overflowed),
		.ram_wr_en        (ram_wr_en),
		.ram_wr_addr      (ram_wr_addr),
		.ram_wr_data      (ram_wr_data),
		.ram_rd_en        (ram_rd_en),
		.ram_rd_addr      (ram_rd_addr),
		.ram_rd_data      (ram_rd_data)
	);

endmodule
